// ----- sv/rfse_pkg.sv -----
// ----------------------------------------------------------------------------
// rfse_pkg
// Shared types, codes and helper functions of the radio frame symbol encoder.
// ----------------------------------------------------------------------------
package rfse_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned HDR_BYTES   = 5;
  localparam int unsigned LEN_BIAS    = 7;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int unsigned CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int unsigned STEP_W      = 3;

  localparam logic [15:0] CRC_INIT = 16'hffff;
  localparam logic [15:0] CRC_POLY = 16'h8408;

  // request types
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
  localparam logic [1:0] STATUS_STRAY   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_NET_ADDR = 2'd0;
  localparam logic [1:0] CFG_DEV_ADDR = 2'd1;
  localparam logic [1:0] CFG_TBL_LO   = 2'd2;
  localparam logic [1:0] CFG_TBL_HI   = 2'd3;

  // command kinds passed from the front end to the back end
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERR_LEN = 2'd2;
  localparam logic [1:0] KIND_ERR_STR = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic       crc_after;  // frame closes with its CRC after this command
    logic [7:0] dest;
    logic [7:0] port;
    logic [7:0] len;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  net_addr;
    logic [7:0]  dev_addr;
    logic [63:0] tbl_lo;
    logic [63:0] tbl_hi;
  } cfg_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] map_nibble(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] nib);
    logic [63:0] word;
    word = nib[3] ? hi : lo;
    return word[{nib[2:0], 3'b000} +: 8];
  endfunction

endpackage

// ----- sv/rfse_if.sv -----
// ----------------------------------------------------------------------------
// rfse channel interfaces
// Valid/ready channels for request items, symbol results and register writes.
// ----------------------------------------------------------------------------
interface rfse_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] dest;
  logic [7:0] port;
  logic [7:0] payload_len;
  logic [7:0] payload_byte;

  modport source (output valid, req_type, dest, port, payload_len, payload_byte,
                  input ready);
  modport sink   (input valid, req_type, dest, port, payload_len, payload_byte,
                  output ready);
endinterface

interface rfse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic [1:0] status;
  logic       last;
  logic       frame_end;

  modport source (output valid, symbol, status, last, frame_end, input ready);
  modport sink   (input valid, symbol, status, last, frame_end, output ready);
endinterface

interface rfse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/radio_frame_symbol_encoder.sv -----
// ----------------------------------------------------------------------------
// radio_frame_symbol_encoder
// Builds short radio frames as nibble symbols with a trailing CRC-CCITT.
// ----------------------------------------------------------------------------
// Throughput: one symbol per cycle while out_ch is ready and an item is
//   queued, limited by the single output register; a payload item gives
//   its byte's nibbles (plus the CRC if it closes the frame), a start item its
//   header (plus the CRC for an empty payload); an error item, one result.
// Reset: rst_n, synchronous, active low; clears the queue, frame tracking,
//   output valid and all configuration registers.
// ----------------------------------------------------------------------------
module radio_frame_symbol_encoder (
  input  logic        clk,
  input  logic        rst_n,
  rfse_in_if.sink     in_ch,
  rfse_out_if.source  out_ch,
  rfse_cfg_if.sink    cfg_ch
);
  import rfse_pkg::*;

  // Configuration registers. Writes are only expected while the block is
  // idle, so the back end reads them live without any shadowing.
  cfg_t cfg_r;

  // Front end to queue, queue to back end
  logic push, push_ready;
  cmd_t push_cmd;
  logic pop, head_valid;
  cmd_t head_cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_NET_ADDR: cfg_r.net_addr <= cfg_ch.data[7:0];
        CFG_DEV_ADDR: cfg_r.dev_addr <= cfg_ch.data[7:0];
        CFG_TBL_LO:   cfg_r.tbl_lo   <= cfg_ch.data;
        CFG_TBL_HI:   cfg_r.tbl_hi   <= cfg_ch.data;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  // Front end: keeps frame_open / bytes_left and tags each transaction with
  // its kind and whether the frame closes after it.
  rfse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Two-entry queue lets the front end take the next item while the back end
  // is still streaming symbols of the previous one.
  rfse_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .not_full  (push_ready),
    .pop       (pop),
    .not_empty (head_valid),
    .head_cmd  (head_cmd)
  );

  // Back end: byte sequencer, CRC accumulator, symbol mapping, output register.
  rfse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .cfg        (cfg_r),
    .out_ch     (out_ch)
  );

endmodule

// ----- sv/rfse_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// rfse_cmd_fifo
// Short command queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module rfse_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rfse_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output rfse_pkg::cmd_t head_cmd
);
  import rfse_pkg::*;

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
    return (p == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : p + CMD_PTR_W'(1);
  endfunction

  assign not_full  = (cnt_r != CMD_CNT_W'(CMD_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- sv/rfse_front.sv -----
// ----------------------------------------------------------------------------
// rfse_front
// Accepts request items, tracks the open frame and classifies each item.
// ----------------------------------------------------------------------------
module rfse_front (
  input  logic           clk,
  input  logic           rst_n,
  rfse_in_if.sink        in_ch,
  output logic           push,
  output rfse_pkg::cmd_t push_cmd,
  input  logic           push_ready
);
  import rfse_pkg::*;

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] left_dec;

  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready;
  assign left_dec    = left_r - 8'd1;

  always_comb begin
    open_nxt           = open_r;
    left_nxt           = left_r;
    push_cmd.kind      = KIND_START;
    push_cmd.crc_after = 1'b0;
    push_cmd.dest      = in_ch.dest;
    push_cmd.port      = in_ch.port;
    push_cmd.len       = in_ch.payload_len;
    push_cmd.data      = in_ch.payload_byte;
    if (in_ch.req_type == REQ_START) begin
      if (in_ch.payload_len > 8'(MAX_PAYLOAD)) begin
        push_cmd.kind = KIND_ERR_LEN;
        open_nxt      = 1'b0;
        left_nxt      = '0;
      end else begin
        push_cmd.crc_after = (in_ch.payload_len == '0);
        open_nxt           = (in_ch.payload_len != '0);
        left_nxt           = in_ch.payload_len;
      end
    end else if (!open_r) begin
      push_cmd.kind = KIND_ERR_STR;
    end else begin
      push_cmd.kind      = KIND_PAYLOAD;
      push_cmd.crc_after = (left_dec == '0);
      open_nxt           = (left_dec != '0);
      left_nxt           = left_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= '0;
    end else if (push) begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

// ----- sv/rfse_back.sv -----
// ----------------------------------------------------------------------------
// rfse_back
// Expands commands into frame bytes, runs the CRC and emits nibble symbols.
// ----------------------------------------------------------------------------
module rfse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  rfse_pkg::cmd_t head_cmd,
  output logic           pop,
  input  rfse_pkg::cfg_t cfg,
  rfse_out_if.source     out_ch
);
  import rfse_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              nib_r, nib_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              vld_r, vld_nxt;
  logic [7:0]        sym_r;
  logic [1:0]        status_r;
  logic              last_r, end_r;

  logic              produce, is_err, is_crc, fin;
  logic [STEP_W-1:0] data_cnt, final_step;
  logic [7:0]        cur_byte, cur_sym;
  logic [15:0]       crc_base, crc_inv;
  logic [3:0]        nib;

  assign out_ch.valid     = vld_r;
  assign out_ch.symbol    = sym_r;
  assign out_ch.status    = status_r;
  assign out_ch.last      = last_r;
  assign out_ch.frame_end = end_r;

  assign produce = head_valid && (!vld_r || out_ch.ready);
  assign is_err  = (head_cmd.kind == KIND_ERR_LEN) || (head_cmd.kind == KIND_ERR_STR);
  assign crc_inv = ~crc_r;

  always_comb begin
    data_cnt   = (head_cmd.kind == KIND_START) ? STEP_W'(HDR_BYTES) : STEP_W'(1);
    final_step = head_cmd.crc_after ? data_cnt + STEP_W'(1) : data_cnt - STEP_W'(1);
    is_crc     = (step_r >= data_cnt);
    cur_byte   = head_cmd.data;
    if (is_crc) begin
      cur_byte = (step_r == data_cnt) ? crc_inv[7:0] : crc_inv[15:8];
    end else if (head_cmd.kind == KIND_START) begin
      case (step_r)
        3'd0:    cur_byte = head_cmd.len + 8'(LEN_BIAS);
        3'd1:    cur_byte = cfg.net_addr;
        3'd2:    cur_byte = cfg.dev_addr;
        3'd3:    cur_byte = head_cmd.dest;
        3'd4:    cur_byte = head_cmd.port;
        default: cur_byte = head_cmd.data;
      endcase
    end
    nib      = nib_r ? cur_byte[3:0] : cur_byte[7:4];
    cur_sym  = map_nibble(cfg.tbl_lo, cfg.tbl_hi, nib);
    fin      = is_err || (nib_r && (step_r == final_step));
    crc_base = ((head_cmd.kind == KIND_START) && (step_r == '0)) ? CRC_INIT : crc_r;
  end

  always_comb begin
    step_nxt = step_r;
    nib_nxt  = nib_r;
    crc_nxt  = crc_r;
    vld_nxt  = vld_r;
    pop      = 1'b0;
    if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
    if (produce) begin
      vld_nxt = 1'b1;
      if (fin) begin
        pop      = 1'b1;
        step_nxt = '0;
        nib_nxt  = 1'b0;
      end else if (nib_r) begin
        nib_nxt  = 1'b0;
        step_nxt = step_r + STEP_W'(1);
      end else begin
        nib_nxt = 1'b1;
      end
      if (!is_err && nib_r && !is_crc) begin
        crc_nxt = crc_byte(crc_base, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      nib_r  <= 1'b0;
      crc_r  <= CRC_INIT;
      vld_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      nib_r  <= nib_nxt;
      crc_r  <= crc_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      if (is_err) begin
        sym_r    <= '0;
        status_r <= (head_cmd.kind == KIND_ERR_LEN) ? STATUS_TOO_BIG : STATUS_STRAY;
        last_r   <= 1'b1;
        end_r    <= 1'b0;
      end else begin
        sym_r    <= cur_sym;
        status_r <= STATUS_OK;
        last_r   <= fin;
        end_r    <= fin && head_cmd.crc_after;
      end
    end
  end

endmodule

// ----- sv/rfse_checker.sv -----
// ----------------------------------------------------------------------------
// rfse_checker
// Port-level assertions on the encoder's result channel, bound to the top.
// ----------------------------------------------------------------------------
module rfse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol,
  input logic [1:0] out_status,
  input logic       out_last,
  input logic       out_frame_end
);
  import rfse_pkg::*;

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_last))
    else $error("stalled result changed");

  // Error results are single, zero-symbol and never end a frame.
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
      out_last && !out_frame_end && (out_symbol == 8'h00))
    else $error("malformed error result");

  // Frame end is always the final result of its transaction.
  a_fend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last && (out_status == STATUS_OK))
    else $error("frame end not on last result");

  // Status never carries the unused code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STATUS_OK) || (out_status == STATUS_TOO_BIG) ||
                  (out_status == STATUS_STRAY))
    else $error("bad status code");

endmodule

bind radio_frame_symbol_encoder rfse_checker u_rfse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_symbol    (out_ch.symbol),
  .out_status    (out_ch.status),
  .out_last      (out_ch.last),
  .out_frame_end (out_ch.frame_end)
);
